>>> design/bcgd_pkg.sv
// ----------------------------------------------------------------------------
// bcgd_pkg
// Shared types and constants of the button click gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bcgd_pkg;

  localparam int unsigned TIMER_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned TICKS_W        = 16;
  localparam int unsigned CODE_W         = 4;
  localparam int unsigned CTRL_W         = 7;

  localparam logic [CTRL_W-1:0] MidiCenter = 7'd64;

  localparam logic [1:0] ClicksNone = 2'd0;
  localparam logic [1:0] ClicksOne  = 2'd1;
  localparam logic [1:0] ClicksTwo  = 2'd2;

  typedef enum logic [2:0] {
    TRIG_NONE   = 3'd0,
    TRIG_CLICK  = 3'd1,
    TRIG_DOUBLE = 3'd2,
    TRIG_LONG   = 3'd3,
    TRIG_DEC    = 3'd4,
    TRIG_INC    = 3'd5
  } trigger_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOUBLE_TICKS   = 3'd0,
    CFG_LONG_TICKS     = 3'd1,
    CFG_DEBOUNCE_TICKS = 3'd2,
    CFG_CLICK_EVT      = 3'd3,
    CFG_DOUBLE_EVT     = 3'd4,
    CFG_LONG_EVT       = 3'd5,
    CFG_DEC_EVT        = 3'd6,
    CFG_INC_EVT        = 3'd7
  } cfg_index_e;

  typedef struct packed {
    logic              button_level;
    logic [CTRL_W-1:0] controller_value;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] event_code;
    trigger_kind_e     trigger_kind;
    logic              recentre_request;
  } out_item_t;

  // result handed from the update logic to the output stage
  typedef struct packed {
    logic      push;
    out_item_t item;
  } result_t;

endpackage

`default_nettype wire

>>> design/button_click_gesture_detector_top.sv
// Each accepted tick gives a result in the result register or in the skid entry.
// Throughput: one tick per cycle while in_stall_o is low, set by the state update.
// A result register plus one skid entry let input continue for one more tick
// while the output is stalled; in_stall_o rises only when both are full.
// Reset (async, active low) clears counters and event codes; last level is released.
// ----------------------------------------------------------------------------
// button_click_gesture_detector_top
// Click, double click, long press and dec/inc detection on update ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_gesture_detector_top #(
  parameter int unsigned TimerBits = bcgd_pkg::TIMER_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire bcgd_pkg::in_item_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output bcgd_pkg::out_item_t                  out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [bcgd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bcgd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bcgd_pkg::*;

  logic    accept;
  logic    full;
  result_t result;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  bcgd_core #(
    .TimerBits(TimerBits)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result)
  );

  bcgd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .result_i   (result),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

>>> design/bcgd_core.sv
// ----------------------------------------------------------------------------
// bcgd_core
// Configuration registers, gesture state and the single-tick update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module bcgd_core #(
  parameter int unsigned TimerBits = bcgd_pkg::TIMER_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire bcgd_pkg::in_item_t                item_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [bcgd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [bcgd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output bcgd_pkg::result_t                      result_o
);
  import bcgd_pkg::*;

  localparam logic [TimerBits-1:0] One = {{(TimerBits-1){1'b0}}, 1'b1};

  logic [TICKS_W-1:0] dbl_ticks_q, long_ticks_q, deb_ticks_q;
  logic [CODE_W-1:0]  click_evt_q, double_evt_q, long_evt_q, dec_evt_q, inc_evt_q;

  logic [TimerBits-1:0] gt_q, gt_d, dc_q, dc_d;
  logic [1:0]           cc_q, cc_d;
  logic                 ll_q, ll_d;

  logic [TimerBits+TICKS_W-1:0] dbl_ext, long_ext, deb_ext, cfg_ext;
  logic [TimerBits-1:0]         dbl, lng, deb, cfg_t;
  logic                         done, held;
  out_item_t                    res;

  // register values seen at timer width
  assign dbl_ext  = {{TimerBits{1'b0}}, dbl_ticks_q};
  assign long_ext = {{TimerBits{1'b0}}, long_ticks_q};
  assign deb_ext  = {{TimerBits{1'b0}}, deb_ticks_q};
  assign cfg_ext  = {{TimerBits{1'b0}}, cfg_data_i};
  assign dbl      = dbl_ext[TimerBits-1:0];
  assign lng      = long_ext[TimerBits-1:0];
  assign deb      = deb_ext[TimerBits-1:0];
  assign cfg_t    = cfg_ext[TimerBits-1:0];

  always_comb begin
    gt_d = gt_q;
    dc_d = dc_q;
    cc_d = cc_q;
    ll_d = ll_q;
    done = 1'b0;
    held = 1'b0;
    res  = '{event_code: '0, trigger_kind: TRIG_NONE, recentre_request: 1'b0};
    if (dec_evt_q != '0 && item_i.controller_value < MidiCenter) begin
      gt_d = lng;
      cc_d = ClicksNone;
      res  = '{event_code: dec_evt_q, trigger_kind: TRIG_DEC, recentre_request: 1'b1};
    end else if (inc_evt_q != '0 && item_i.controller_value > MidiCenter) begin
      gt_d = lng;
      cc_d = ClicksNone;
      res  = '{event_code: inc_evt_q, trigger_kind: TRIG_INC, recentre_request: 1'b1};
    end else begin
      if (gt_q < lng) begin
        gt_d = gt_q + One;
        if (gt_d == dbl && ll_q && cc_q == ClicksOne) begin
          gt_d = lng;
          cc_d = ClicksNone;
          done = 1'b1;
          res  = '{event_code: click_evt_q, trigger_kind: TRIG_CLICK,
                   recentre_request: 1'b0};
        end else if (gt_d == lng) begin
          held = !ll_q && cc_q == ClicksOne;
          cc_d = ClicksNone;
          if (held) begin
            done = 1'b1;
            res  = '{event_code: long_evt_q, trigger_kind: TRIG_LONG,
                     recentre_request: 1'b0};
          end
        end
      end
      if (!done) begin
        priority if (dc_q < deb) begin
          dc_d = dc_q + One;
        end else if (!item_i.button_level) begin
          if (ll_q) begin
            ll_d = 1'b0;
            dc_d = '0;
            if (cc_d == ClicksNone) gt_d = '0;
            if (cc_d != ClicksTwo) cc_d = cc_d + 2'd1;
          end
        end else if (!ll_q) begin
          ll_d = 1'b1;
          dc_d = '0;
          if (cc_d == ClicksOne &&
              (double_evt_q == '0 || (gt_d >= dbl && gt_d < lng))) begin
            gt_d = lng;
            cc_d = ClicksNone;
            res  = '{event_code: click_evt_q, trigger_kind: TRIG_CLICK,
                     recentre_request: 1'b0};
          end else if (cc_d == ClicksTwo) begin
            gt_d = lng;
            cc_d = ClicksNone;
            res  = '{event_code: double_evt_q, trigger_kind: TRIG_DOUBLE,
                     recentre_request: 1'b0};
          end
        end else begin
          // still released, nothing to do
        end
      end
    end
  end

  assign result_o = '{push: accept_i, item: res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbl_ticks_q  <= '0;
      long_ticks_q <= '0;
      deb_ticks_q  <= '0;
      click_evt_q  <= '0;
      double_evt_q <= '0;
      long_evt_q   <= '0;
      dec_evt_q    <= '0;
      inc_evt_q    <= '0;
      gt_q         <= '0;
      dc_q         <= '0;
      cc_q         <= ClicksNone;
      ll_q         <= 1'b1;
    end else if (accept_i) begin
      gt_q <= gt_d;
      dc_q <= dc_d;
      cc_q <= cc_d;
      ll_q <= ll_d;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_DOUBLE_TICKS:   dbl_ticks_q <= cfg_data_i;
        CFG_LONG_TICKS: begin
          long_ticks_q <= cfg_data_i;
          gt_q         <= cfg_t;
        end
        CFG_DEBOUNCE_TICKS: begin
          deb_ticks_q <= cfg_data_i;
          dc_q        <= cfg_t;
        end
        CFG_CLICK_EVT:      click_evt_q  <= cfg_data_i[CODE_W-1:0];
        CFG_DOUBLE_EVT:     double_evt_q <= cfg_data_i[CODE_W-1:0];
        CFG_LONG_EVT:       long_evt_q   <= cfg_data_i[CODE_W-1:0];
        CFG_DEC_EVT:        dec_evt_q    <= cfg_data_i[CODE_W-1:0];
        CFG_INC_EVT:        inc_evt_q    <= cfg_data_i[CODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/bcgd_out_stage.sv
// ----------------------------------------------------------------------------
// bcgd_out_stage
// Result register with a skid entry so a stalled result does not block input.
// ----------------------------------------------------------------------------
`default_nettype none

module bcgd_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bcgd_pkg::result_t   result_i,
  output logic                     full_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output bcgd_pkg::out_item_t      out_data_o
);
  import bcgd_pkg::*;

  logic      out_valid_q, skid_valid_q;
  out_item_t out_data_q, skid_data_q;
  logic      pop;

  assign pop         = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (result_i.push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_data_q <= skid_data_q;
    end else if (result_i.push) begin
      if (out_valid_q && !pop) begin
        skid_data_q <= result_i.item;
      end else begin
        out_data_q <= result_i.item;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/bcgd_checker.sv
// ----------------------------------------------------------------------------
// bcgd_checker
// Port-level checks of the gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bcgd_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire bcgd_pkg::out_item_t out_data_o
);
  import bcgd_pkg::*;

  // recentre only accompanies a dec or inc trigger
  a_recentre_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.recentre_request |->
      (out_data_o.trigger_kind == TRIG_DEC || out_data_o.trigger_kind == TRIG_INC))
    else $error("recentre without dec/inc trigger");

  // a non-zero code always comes with a fired trigger
  a_code_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_code != '0 |->
      out_data_o.trigger_kind != TRIG_NONE)
    else $error("event code without trigger");

  // input backs up only behind a held result
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall rose without output stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind button_click_gesture_detector_top bcgd_checker u_bcgd_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button click gesture detector. A scoreboard
// class tracks the timers, click count and last level of the detector and
// predicts one trigger per update tick; results are compared field by field
// across several register settings, with random idling and stalling.
// ----------------------------------------------------------------------------

module tb_top;
  import bcgd_pkg::*;

  class gesture_scoreboard;
    logic [15:0] dbl_ticks, long_ticks, deb_ticks;
    logic [3:0]  click_code, double_code, long_code, dec_code, inc_code;
    logic [15:0] gesture_timer, debounce_count;
    logic [1:0]  clicks;
    logic        last_level;
    out_item_t   pending_triggers[$];
    int unsigned errors, ticks, results;
    int unsigned kind_seen[6];

    function new();
      dbl_ticks = '0; long_ticks = '0; deb_ticks = '0;
      click_code = '0; double_code = '0; long_code = '0;
      dec_code = '0; inc_code = '0;
      gesture_timer = '0; debounce_count = '0;
      clicks = ClicksNone; last_level = 1'b1;
      errors = 0; ticks = 0; results = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void write_reg(cfg_index_e idx, logic [15:0] data);
      case (idx)
        CFG_DOUBLE_TICKS: dbl_ticks = data;
        CFG_LONG_TICKS: begin
          long_ticks = data;
          gesture_timer = data;
        end
        CFG_DEBOUNCE_TICKS: begin
          deb_ticks = data;
          debounce_count = data;
        end
        CFG_CLICK_EVT:  click_code  = data[3:0];
        CFG_DOUBLE_EVT: double_code = data[3:0];
        CFG_LONG_EVT:   long_code   = data[3:0];
        CFG_DEC_EVT:    dec_code    = data[3:0];
        CFG_INC_EVT:    inc_code    = data[3:0];
        default: ;
      endcase
    endfunction

    function void restart_gesture();
      gesture_timer = long_ticks;
      clicks = ClicksNone;
    endfunction

    function out_item_t trigger(logic [3:0] code, trigger_kind_e kind, logic rc);
      out_item_t r;
      r.event_code = code;
      r.trigger_kind = kind;
      r.recentre_request = rc;
      return r;
    endfunction

    function out_item_t predict_trigger(in_item_t it);
      logic held;
      if (dec_code != 0 && it.controller_value < MidiCenter) begin
        restart_gesture();
        return trigger(dec_code, TRIG_DEC, 1'b1);
      end
      if (inc_code != 0 && it.controller_value > MidiCenter) begin
        restart_gesture();
        return trigger(inc_code, TRIG_INC, 1'b1);
      end
      if (gesture_timer < long_ticks) begin
        gesture_timer = gesture_timer + 16'd1;
        // released after one press and the double-click window ran out
        if (gesture_timer == dbl_ticks && last_level && clicks == ClicksOne) begin
          restart_gesture();
          return trigger(click_code, TRIG_CLICK, 1'b0);
        end
        if (gesture_timer == long_ticks) begin
          held = !last_level && clicks == ClicksOne;
          restart_gesture();
          if (held) return trigger(long_code, TRIG_LONG, 1'b0);
        end
      end
      if (debounce_count < deb_ticks) begin
        debounce_count = debounce_count + 16'd1;
        return trigger(4'd0, TRIG_NONE, 1'b0);
      end
      if (!it.button_level) begin
        if (last_level) begin
          last_level = 1'b0;
          debounce_count = '0;
          if (clicks == ClicksNone) gesture_timer = '0;
          if (clicks < ClicksTwo) clicks = clicks + 2'd1;
        end
      end else if (!last_level) begin
        last_level = 1'b1;
        debounce_count = '0;
        if (clicks == ClicksOne && (double_code == 0 ||
            (gesture_timer >= dbl_ticks && gesture_timer < long_ticks))) begin
          restart_gesture();
          return trigger(click_code, TRIG_CLICK, 1'b0);
        end
        if (clicks == ClicksTwo) begin
          restart_gesture();
          return trigger(double_code, TRIG_DOUBLE, 1'b0);
        end
      end
      return trigger(4'd0, TRIG_NONE, 1'b0);
    endfunction

    function void note_request(in_item_t it);
      pending_triggers.push_back(predict_trigger(it));
      ticks++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      results++;
      if (pending_triggers.size() == 0) begin
        $error("result arrived with nothing outstanding: code %0d kind %0d",
               got.event_code, got.trigger_kind);
        errors++;
        return;
      end
      exp = pending_triggers.pop_front();
      if (got.event_code !== exp.event_code) begin
        $error("event_code: expected %0d, got %0d", exp.event_code, got.event_code);
        errors++;
      end
      if (got.trigger_kind !== exp.trigger_kind) begin
        $error("trigger_kind: expected %0d, got %0d", exp.trigger_kind, got.trigger_kind);
        errors++;
      end
      if (got.recentre_request !== exp.recentre_request) begin
        $error("recentre_request: expected %0d, got %0d",
               exp.recentre_request, got.recentre_request);
        errors++;
      end
      if (exp.trigger_kind <= TRIG_INC) kind_seen[exp.trigger_kind]++;
    endfunction

    function int pending();
      return pending_triggers.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  gesture_scoreboard sb = new();
  bit steady = 1'b0;      // no random idling on either side while set
  int settings = 0;
  int hold_left = 0;
  int next_hold_at = 300;

  button_click_gesture_detector_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #2_400_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: check accepted results, then pick next cycle's stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (hold_left == 0 && sb.results >= next_hold_at) begin
      hold_left = 60;
      next_hold_at += 900;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(0, 99) < 18);
    end
  end

  task automatic drive_tick(logic level, logic [CTRL_W-1:0] value);
    in_item_t it;
    it.button_level = level;
    it.controller_value = value;
    if (!steady && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(it);
  endtask

  task automatic repeat_tick(logic level, logic [CTRL_W-1:0] value, int n);
    repeat (n) drive_tick(level, value);
  endtask

  // stop sending and let every outstanding result drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic load_regs(logic [15:0] dbl, logic [15:0] lng, logic [15:0] deb,
                           logic [15:0] click, logic [15:0] dbl_evt, logic [15:0] long_evt,
                           logic [15:0] dec, logic [15:0] inc);
    settle();
    write_reg(CFG_LONG_TICKS, lng);
    write_reg(CFG_DOUBLE_TICKS, dbl);
    write_reg(CFG_DEBOUNCE_TICKS, deb);
    write_reg(CFG_CLICK_EVT, click);
    write_reg(CFG_DOUBLE_EVT, dbl_evt);
    write_reg(CFG_LONG_EVT, long_evt);
    write_reg(CFG_DEC_EVT, dec);
    write_reg(CFG_INC_EVT, inc);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic random_setting(bit steer);
    logic [15:0] d, l;
    d = 16'($urandom_range(0, 10));
    l = 16'($urandom_range(d, 24));
    load_regs(d, l, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
              steer ? 16'($urandom_range(0, 15)) : 16'd0,
              steer ? 16'($urandom_range(0, 15)) : 16'd0);
  endtask

  // alternating press and release runs, with some bouncing runs and off-centre values
  task automatic gesture_run(int n);
    int done_n, len, short_span, long_span, mode;
    logic level;
    logic [CTRL_W-1:0] value;
    done_n = 0;
    level = 1'b1;
    short_span = int'(sb.deb_ticks) + int'(sb.dbl_ticks) + 2;
    long_span = int'(sb.deb_ticks) + int'(sb.long_ticks) + 4;
    if (short_span > 30) short_span = 30;
    if (long_span > 30) long_span = 30;
    while (done_n < n) begin
      level = ~level;
      mode = $urandom_range(0, 9);
      len = $urandom_range(0, 1) ? $urandom_range(1, short_span)
                                 : $urandom_range(1, long_span);
      for (int k = 0; k < len && done_n < n; k++) begin
        value = ($urandom_range(0, 99) < 85) ? MidiCenter : CTRL_W'($urandom_range(0, 127));
        drive_tick(mode == 0 ? logic'($urandom_range(0, 1)) : level, value);
        done_n++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all registers zero: a release still reports a click with code zero
    drive_tick(1'b0, 7'd0);
    drive_tick(1'b1, 7'd127);
    drive_tick(1'b0, 7'd0);
    drive_tick(1'b1, 7'd0);

    load_regs(16'd3, 16'd6, 16'd1, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7);
    repeat_tick(1'b0, MidiCenter, 2);   // single click, reported when the window closes
    repeat_tick(1'b1, MidiCenter, 4);
    repeat_tick(1'b0, MidiCenter, 1);   // press and release again: a click, reported when the window closes
    repeat_tick(1'b1, MidiCenter, 2);
    repeat_tick(1'b0, MidiCenter, 2);
    repeat_tick(1'b1, MidiCenter, 1);
    repeat_tick(1'b0, MidiCenter, 6);   // held press, ended by a dec trigger before the long limit
    drive_tick(1'b1, 7'd0);
    drive_tick(1'b1, 7'd63);
    drive_tick(1'b1, MidiCenter);
    drive_tick(1'b1, 7'd65);
    drive_tick(1'b1, 7'd127);

    load_regs(16'd4, 16'd12, 16'd2, 16'd1, 16'd2, 16'd3, 16'd0, 16'd0);
    gesture_run(300);
    random_setting(1'b1);
    gesture_run(250);
    steady = 1'b1;
    random_setting(1'b0);
    gesture_run(250);
    steady = 1'b0;
    // long limit under the double-click limit
    load_regs(16'd9, 16'd5, 16'd1, 16'd11, 16'd12, 16'd13, 16'd0, 16'd14);
    gesture_run(200);
    load_regs(16'd0, 16'd0, 16'd0, 16'd15, 16'd15, 16'd15, 16'd15, 16'd15);
    gesture_run(200);
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFF0,
              16'hFFFF);
    gesture_run(100);
    load_regs(16'd2, 16'hFFFF, 16'd0, 16'd9, 16'd0, 16'd10, 16'd8, 16'd0);
    gesture_run(200);
    random_setting(1'b1);
    gesture_run(250);
    random_setting(1'b1);
    gesture_run(250);

    settle();
    $display("Covered %0d ticks under %0d register settings, %0d results checked",
             sb.ticks, settings, sb.results);
    $display("Triggers: %0d click, %0d double, %0d long, %0d dec, %0d inc",
             sb.kind_seen[TRIG_CLICK], sb.kind_seen[TRIG_DOUBLE], sb.kind_seen[TRIG_LONG],
             sb.kind_seen[TRIG_DEC], sb.kind_seen[TRIG_INC]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
